[design/pew_pkg.sv]
// Package for the particle Euler step with wall contact.
// Shared widths, configuration register codes and the configuration bundle.
// No dependencies.
package pew_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int POS_W             = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP     = 3'd0,
    REG_BOUNCE_FACTOR = 3'd1,
    REG_WORLD_MIN_X   = 3'd2,
    REG_WORLD_MIN_Y   = 3'd3,
    REG_WORLD_MAX_X   = 3'd4,
    REG_WORLD_MAX_Y   = 3'd5
  } cfg_reg_t;

  // Register values, zero or sign extended to full width.
  typedef struct packed {
    logic        [POS_W-1:0] time_step;
    logic signed [POS_W-1:0] bounce_factor;
    logic signed [POS_W-1:0] world_min_x;
    logic signed [POS_W-1:0] world_min_y;
    logic signed [POS_W-1:0] world_max_x;
    logic signed [POS_W-1:0] world_max_y;
  } cfg_t;

endpackage

[design/pew_if.sv]
// Channel interfaces: particle requests in, results out, configuration writes.
// Depends on pew_pkg.
interface pew_particle_if;
  import pew_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] vel_x;
  logic signed [POS_W-1:0] vel_y;
  logic                    last_in;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, last_in, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, last_in, output ready);
endinterface

interface pew_result_if #(parameter int FRAC_BITS = pew_pkg::FRAC_BITS_DEFAULT);
  import pew_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [POS_W-1:0]     new_pos_x;
  logic signed [POS_W-1:0]     new_pos_y;
  logic signed [FRAC_BITS+5:0] new_vel_x;
  logic signed [FRAC_BITS+5:0] new_vel_y;
  logic                        last_out;
  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, last_out,
                  input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, last_out,
                  output ready);
endinterface

interface pew_cfg_if;
  import pew_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/pew_cfg_regs.sv]
// Configuration register file: time step, bounce factor and world box.
// Depends on pew_pkg and pew_cfg_if.
module pew_cfg_regs #(
  parameter int FRAC_BITS = pew_pkg::FRAC_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  pew_cfg_if.sink      cfg,
  output pew_pkg::cfg_t cfg_q
);
  import pew_pkg::*;

  localparam int TS_W = FRAC_BITS + 1;
  localparam int BF_W = FRAC_BITS + 2;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam logic [TS_W-1:0]  TS_RESET  = TS_W'((ONE + 30) / 60);
  localparam logic [BF_W-1:0]  BF_RESET  = BF_W'(-(ONE / 2));
  localparam logic [POS_W-1:0] MAX_RESET = POS_W'(1000 * ONE);

  logic [TS_W-1:0]  time_step;
  logic [BF_W-1:0]  bounce_factor;
  logic [POS_W-1:0] world_min_x;
  logic [POS_W-1:0] world_min_y;
  logic [POS_W-1:0] world_max_x;
  logic [POS_W-1:0] world_max_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step     <= TS_RESET;
      bounce_factor <= BF_RESET;
      world_min_x   <= '0;
      world_min_y   <= '0;
      world_max_x   <= MAX_RESET;
      world_max_y   <= MAX_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_TIME_STEP:     time_step     <= cfg.data[TS_W-1:0];
        REG_BOUNCE_FACTOR: bounce_factor <= cfg.data[BF_W-1:0];
        REG_WORLD_MIN_X:   world_min_x   <= cfg.data[POS_W-1:0];
        REG_WORLD_MIN_Y:   world_min_y   <= cfg.data[POS_W-1:0];
        REG_WORLD_MAX_X:   world_max_x   <= cfg.data[POS_W-1:0];
        REG_WORLD_MAX_Y:   world_max_y   <= cfg.data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_q.time_step     = {{(POS_W-TS_W){1'b0}}, time_step};
  assign cfg_q.bounce_factor = {{(POS_W-BF_W){bounce_factor[BF_W-1]}}, bounce_factor};
  assign cfg_q.world_min_x   = world_min_x;
  assign cfg_q.world_min_y   = world_min_y;
  assign cfg_q.world_max_x   = world_max_x;
  assign cfg_q.world_max_y   = world_max_y;

endmodule

[design/pew_kinematics.sv]
// Stages 1-3: gravity and velocity clamp, products by dt and bounce factor,
// position advance and rescaled bounce velocity. Depends on pew_pkg, pew_if.
module pew_kinematics #(
  parameter int FRAC_BITS = pew_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  pew_particle_if.sink                     particle_in,
  input  pew_pkg::cfg_t                    cfg_q,
  output logic                             kin_valid,
  input  logic                             kin_ready,
  output logic signed [pew_pkg::POS_W:0]   kin_pos_x,
  output logic signed [pew_pkg::POS_W:0]   kin_pos_y,
  output logic signed [FRAC_BITS+5:0]      kin_vel_x,
  output logic signed [FRAC_BITS+5:0]      kin_vel_y,
  output logic signed [FRAC_BITS+5:0]      kin_bvel_x,
  output logic signed [FRAC_BITS+5:0]      kin_bvel_y,
  output logic                             kin_last
);
  import pew_pkg::*;

  localparam int TS_W  = FRAC_BITS + 1;
  localparam int BF_W  = FRAC_BITS + 2;
  localparam int VEL_W = FRAC_BITS + 6;
  localparam int PM_W  = 2 * FRAC_BITS + 8;
  localparam int RS_W  = PM_W - FRAC_BITS;
  localparam int EXT_W = POS_W + 1;
  localparam int GR_W  = TS_W + 4;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam logic signed [EXT_W-1:0] LIM_E  = EXT_W'(25 * ONE);
  localparam logic signed [EXT_W-1:0] NLIM_E = -LIM_E;
  localparam logic signed [RS_W-1:0]  LIM_R  = RS_W'(25 * ONE);
  localparam logic signed [RS_W-1:0]  NLIM_R = -LIM_R;
  localparam logic signed [PM_W-1:0]  HALF   = PM_W'(ONE / 2);

  logic valid1, valid2, valid3;
  logic adv1, adv2, adv3;

  logic signed [POS_W-1:0] pos1_x, pos1_y, pos2_x, pos2_y;
  logic signed [VEL_W-1:0] vel1_x, vel1_y, vel2_x, vel2_y;
  logic                    last1, last2;
  logic signed [PM_W-1:0]  prod_dx, prod_dy, prod_bx, prod_by;

  logic [TS_W-1:0]          dt;
  logic signed [TS_W:0]     dt_s;
  logic signed [BF_W-1:0]   bf;
  logic [GR_W-1:0]          grav;
  logic signed [EXT_W-1:0]  vx_e, vy_g;
  logic signed [VEL_W-1:0]  vel1_x_next, vel1_y_next;
  logic signed [PM_W-1:0]   tdx, tdy, tbx, tby;
  logic signed [RS_W-1:0]   step_x, step_y, rb_x, rb_y;

  assign adv3 = !valid3 || kin_ready;
  assign adv2 = !valid2 || adv3;
  assign adv1 = !valid1 || adv2;
  assign particle_in.ready = adv1;
  assign kin_valid = valid3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (adv1) valid1 <= particle_in.valid;
      if (adv2) valid2 <= valid1;
      if (adv3) valid3 <= valid2;
    end
  end

  // stage 1: gravity, velocity clamp
  always_comb begin
    dt   = cfg_q.time_step[TS_W-1:0];
    dt_s = $signed({1'b0, dt});
    bf   = $signed(cfg_q.bounce_factor[BF_W-1:0]);
    grav = {1'b0, dt, 3'b000} + {3'b000, dt, 1'b0};
    vx_e = $signed({particle_in.vel_x[POS_W-1], particle_in.vel_x});
    vy_g = $signed({particle_in.vel_y[POS_W-1], particle_in.vel_y})
         + $signed({{(EXT_W-GR_W){1'b0}}, grav});
    if (vx_e > LIM_E)       vel1_x_next = LIM_E[VEL_W-1:0];
    else if (vx_e < NLIM_E) vel1_x_next = NLIM_E[VEL_W-1:0];
    else                    vel1_x_next = vx_e[VEL_W-1:0];
    if (vy_g > LIM_E)       vel1_y_next = LIM_E[VEL_W-1:0];
    else if (vy_g < NLIM_E) vel1_y_next = NLIM_E[VEL_W-1:0];
    else                    vel1_y_next = vy_g[VEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      pos1_x <= particle_in.pos_x;
      pos1_y <= particle_in.pos_y;
      vel1_x <= vel1_x_next;
      vel1_y <= vel1_y_next;
      last1  <= particle_in.last_in;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (adv2) begin
      pos2_x  <= pos1_x;
      pos2_y  <= pos1_y;
      vel2_x  <= vel1_x;
      vel2_y  <= vel1_y;
      last2   <= last1;
      prod_dx <= vel1_x * dt_s;
      prod_dy <= vel1_y * dt_s;
      prod_bx <= vel1_x * bf;
      prod_by <= vel1_y * bf;
    end
  end

  // stage 3: round to nearest, ties up; advance; clamp bounce velocity
  always_comb begin
    tdx    = prod_dx + HALF;
    tdy    = prod_dy + HALF;
    tbx    = prod_bx + HALF;
    tby    = prod_by + HALF;
    step_x = $signed(tdx[PM_W-1:FRAC_BITS]);
    step_y = $signed(tdy[PM_W-1:FRAC_BITS]);
    rb_x   = $signed(tbx[PM_W-1:FRAC_BITS]);
    rb_y   = $signed(tby[PM_W-1:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      kin_pos_x <= $signed({pos2_x[POS_W-1], pos2_x})
                 + $signed({{(EXT_W-RS_W){step_x[RS_W-1]}}, step_x});
      kin_pos_y <= $signed({pos2_y[POS_W-1], pos2_y})
                 + $signed({{(EXT_W-RS_W){step_y[RS_W-1]}}, step_y});
      kin_vel_x <= vel2_x;
      kin_vel_y <= vel2_y;
      kin_last  <= last2;
      if (rb_x > LIM_R)       kin_bvel_x <= LIM_R[VEL_W-1:0];
      else if (rb_x < NLIM_R) kin_bvel_x <= NLIM_R[VEL_W-1:0];
      else                    kin_bvel_x <= rb_x[VEL_W-1:0];
      if (rb_y > LIM_R)       kin_bvel_y <= LIM_R[VEL_W-1:0];
      else if (rb_y < NLIM_R) kin_bvel_y <= NLIM_R[VEL_W-1:0];
      else                    kin_bvel_y <= rb_y[VEL_W-1:0];
    end
  end

endmodule

[design/pew_contact.sv]
// Stages 4-6: wall, ceiling and floor contact, position clamp, floor friction,
// and the output register. Depends on pew_pkg and pew_if.
module pew_contact #(
  parameter int FRAC_BITS = pew_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pew_pkg::cfg_t                  cfg_q,
  input  logic                           kin_valid,
  output logic                           kin_ready,
  input  logic signed [pew_pkg::POS_W:0] kin_pos_x,
  input  logic signed [pew_pkg::POS_W:0] kin_pos_y,
  input  logic signed [FRAC_BITS+5:0]    kin_vel_x,
  input  logic signed [FRAC_BITS+5:0]    kin_vel_y,
  input  logic signed [FRAC_BITS+5:0]    kin_bvel_x,
  input  logic signed [FRAC_BITS+5:0]    kin_bvel_y,
  input  logic                           kin_last,
  pew_result_if.source                   particle_out
);
  import pew_pkg::*;

  localparam int VEL_W = FRAC_BITS + 6;
  localparam int MF_W  = VEL_W + FRAC_BITS + 1;
  localparam int EXT_W = POS_W + 1;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0]   FRIC = FRAC_BITS'((85 * ONE + 50) / 100);
  localparam logic signed [MF_W-1:0] HALF = MF_W'(ONE / 2);

  logic valid4, valid5, valid6;
  logic adv4, adv5, adv6;

  logic signed [POS_W-1:0] pos4_x, pos4_y, pos5_x, pos5_y;
  logic signed [VEL_W-1:0] vel4_x, vel4_y, vel5_x, vel5_y;
  logic                    floor4, floor5, last4, last5;
  logic signed [MF_W-1:0]  prod_f;

  logic signed [EXT_W-1:0] min_x, min_y, max_x, max_y;
  logic                    hit_side, hit_ceil, hit_floor;
  logic signed [POS_W-1:0] pos4_x_next, pos4_y_next;
  logic signed [MF_W-1:0]  tf;
  logic signed [FRAC_BITS:0] fric_s;

  assign adv6 = !valid6 || particle_out.ready;
  assign adv5 = !valid5 || adv6;
  assign adv4 = !valid4 || adv5;
  assign kin_ready = adv4;
  assign particle_out.valid = valid6;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      valid5 <= 1'b0;
      valid6 <= 1'b0;
    end else begin
      if (adv4) valid4 <= kin_valid;
      if (adv5) valid5 <= valid4;
      if (adv6) valid6 <= valid5;
    end
  end

  // stage 4: contact tests, velocity select, position clamp
  always_comb begin
    min_x     = $signed({cfg_q.world_min_x[POS_W-1], cfg_q.world_min_x});
    min_y     = $signed({cfg_q.world_min_y[POS_W-1], cfg_q.world_min_y});
    max_x     = $signed({cfg_q.world_max_x[POS_W-1], cfg_q.world_max_x});
    max_y     = $signed({cfg_q.world_max_y[POS_W-1], cfg_q.world_max_y});
    hit_side  = (kin_pos_x >= max_x) || (kin_pos_x <= min_x);
    hit_ceil  = kin_pos_y <= min_y;
    hit_floor = kin_pos_y >= max_y;
    if (kin_pos_x < min_x)      pos4_x_next = cfg_q.world_min_x;
    else if (kin_pos_x > max_x) pos4_x_next = cfg_q.world_max_x;
    else                        pos4_x_next = kin_pos_x[POS_W-1:0];
    if (kin_pos_y < min_y)      pos4_y_next = cfg_q.world_min_y;
    else if (kin_pos_y > max_y) pos4_y_next = cfg_q.world_max_y;
    else                        pos4_y_next = kin_pos_y[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      pos4_x <= pos4_x_next;
      pos4_y <= pos4_y_next;
      vel4_x <= hit_side ? kin_bvel_x : kin_vel_x;
      vel4_y <= hit_ceil ? kin_bvel_y : kin_vel_y;
      floor4 <= hit_floor;
      last4  <= kin_last;
    end
  end

  // stage 5: floor friction product
  assign fric_s = $signed({1'b0, FRIC});

  always_ff @(posedge clk) begin
    if (adv5) begin
      pos5_x <= pos4_x;
      pos5_y <= pos4_y;
      vel5_x <= vel4_x;
      vel5_y <= vel4_y;
      floor5 <= floor4;
      last5  <= last4;
      prod_f <= vel4_x * fric_s;
    end
  end

  // stage 6: output register
  assign tf = prod_f + HALF;

  always_ff @(posedge clk) begin
    if (adv6) begin
      particle_out.new_pos_x <= pos5_x;
      particle_out.new_pos_y <= pos5_y;
      particle_out.last_out  <= last5;
      if (floor5) begin
        particle_out.new_vel_x <= tf[FRAC_BITS+VEL_W-1:FRAC_BITS];
        particle_out.new_vel_y <= '0;
      end else begin
        particle_out.new_vel_x <= vel5_x;
        particle_out.new_vel_y <= vel5_y;
      end
    end
  end

endmodule

[design/particle_euler_wall_step.sv]
// Top level of the particle Euler step with wall contact.
// Depends on pew_pkg, pew_if, pew_cfg_regs, pew_kinematics, pew_contact.
//
// One semi-implicit Euler step per particle: gravity and velocity clamp,
// position advance by v*dt, bounce on side walls and ceiling, stop and
// friction on the floor, then a clamp to the world box. Six register stages
// with valid bits; a particle may be accepted every cycle while the output
// side keeps ready high. Back pressure stalls only as far back as needed, so
// bubbles are squeezed out. Depth is set by the two dependent product steps
// (v*dt and v*bounce, then v*0.85 on the floor), each followed by a rounding
// stage. Configuration writes are always ready and must be made while no
// particle is in flight.
module particle_euler_wall_step #(
  parameter int FRAC_BITS = pew_pkg::FRAC_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  pew_particle_if.sink  particle_in,
  pew_result_if.source  particle_out,
  pew_cfg_if.sink       cfg
);
  import pew_pkg::*;

  localparam int VEL_W = FRAC_BITS + 6;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam logic signed [VEL_W-1:0] VLIM  = VEL_W'(25 * ONE);
  localparam logic signed [VEL_W-1:0] VNLIM = -VLIM;

  cfg_t                    cfg_q;
  logic                    kin_valid;
  logic                    kin_ready;
  logic signed [POS_W:0]   kin_pos_x, kin_pos_y;
  logic signed [VEL_W-1:0] kin_vel_x, kin_vel_y, kin_bvel_x, kin_bvel_y;
  logic                    kin_last;

  pew_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  pew_kinematics #(.FRAC_BITS(FRAC_BITS)) u_kinematics (
    .clk         (clk),
    .rst         (rst),
    .particle_in (particle_in),
    .cfg_q       (cfg_q),
    .kin_valid   (kin_valid),
    .kin_ready   (kin_ready),
    .kin_pos_x   (kin_pos_x),
    .kin_pos_y   (kin_pos_y),
    .kin_vel_x   (kin_vel_x),
    .kin_vel_y   (kin_vel_y),
    .kin_bvel_x  (kin_bvel_x),
    .kin_bvel_y  (kin_bvel_y),
    .kin_last    (kin_last)
  );

  pew_contact #(.FRAC_BITS(FRAC_BITS)) u_contact (
    .clk          (clk),
    .rst          (rst),
    .cfg_q        (cfg_q),
    .kin_valid    (kin_valid),
    .kin_ready    (kin_ready),
    .kin_pos_x    (kin_pos_x),
    .kin_pos_y    (kin_pos_y),
    .kin_vel_x    (kin_vel_x),
    .kin_vel_y    (kin_vel_y),
    .kin_bvel_x   (kin_bvel_x),
    .kin_bvel_y   (kin_bvel_y),
    .kin_last     (kin_last),
    .particle_out (particle_out)
  );

  // pipeline full only when the output is held
  a_full_means_stalled: assert property (@(posedge clk) disable iff (rst)
    !particle_in.ready |-> (particle_out.valid && !particle_out.ready))
    else $error("input stalled while output side is free");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !particle_out.valid)
    else $error("result valid right after reset");

  a_vel_bounded: assert property (@(posedge clk) disable iff (rst)
    particle_out.valid |->
      (particle_out.new_vel_x <= VLIM && particle_out.new_vel_x >= VNLIM &&
       particle_out.new_vel_y <= VLIM && particle_out.new_vel_y >= VNLIM))
    else $error("result velocity outside the clamp range");

endmodule

[verif/particle_euler_wall_step_tb.sv]
// Testbench for particle_euler_wall_step: streams particle requests under several
// register settings and checks every result against a built-in step predictor.
// Depends on pew_pkg, the channel interfaces in pew_if and the design sources.
module particle_euler_wall_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pew_pkg::*;

  localparam int FB = FRAC_BITS_DEFAULT;
  localparam int VEL_W = FB + 6;
  localparam int STEP_W = FB + 1;
  localparam int BOUNCE_W = FB + 2;
  localparam longint ONE = longint'(1) <<< FB;
  localparam longint VEL_LIM = 25 * ONE;
  localparam longint FRICTION = (85 * ONE + 50) / 100;
  localparam longint INT_MAX = (longint'(1) <<< 31) - 1;
  localparam longint INT_MIN = -(longint'(1) <<< 31);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned LONG_HOLD = 300;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int PHASES = 10;
  localparam int DRAIN_LIMIT = 100000;
  localparam longint TIMEOUT_NS = 10_000_000;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic                    last;
  } particle_t;

  typedef struct {
    logic [POS_W-1:0] new_pos_x;
    logic [POS_W-1:0] new_pos_y;
    logic [VEL_W-1:0] new_vel_x;
    logic [VEL_W-1:0] new_vel_y;
    logic             last;
  } step_result_t;

  class step_scoreboard;
    step_result_t expected_steps[$];
    longint dt, bounce, min_x, min_y, max_x, max_y;
    int unsigned mismatches;

    function new();
      dt = (ONE + 30) / 60;
      bounce = -(ONE / 2);
      min_x = 0;
      min_y = 0;
      max_x = 1000 * ONE;
      max_y = 1000 * ONE;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic signed [BOUNCE_W-1:0] b;
      logic signed [POS_W-1:0] s;
      b = data[BOUNCE_W-1:0];
      s = data;
      case (idx)
        REG_TIME_STEP:     dt = longint'(data[STEP_W-1:0]);
        REG_BOUNCE_FACTOR: bounce = b;
        REG_WORLD_MIN_X:   min_x = s;
        REG_WORLD_MIN_Y:   min_y = s;
        REG_WORLD_MAX_X:   max_x = s;
        REG_WORLD_MAX_Y:   max_y = s;
        default: ;
      endcase
    endfunction

    // round to nearest, ties toward +inf
    function longint round_fx(longint x);
      return (x + (ONE >>> 1)) >>> FB;
    endfunction

    function longint clamp_vel(longint v);
      if (v > VEL_LIM) return VEL_LIM;
      if (v < -VEL_LIM) return -VEL_LIM;
      return v;
    endfunction

    function step_result_t euler_wall_step(particle_t p);
      longint px, py, vx, vy;
      step_result_t r;
      px = p.pos_x;
      py = p.pos_y;
      vx = p.vel_x;
      vy = p.vel_y;
      vy = vy + 10 * dt;
      vx = clamp_vel(vx);
      vy = clamp_vel(vy);
      px = px + round_fx(vx * dt);
      py = py + round_fx(vy * dt);
      if (px >= max_x || px <= min_x) vx = clamp_vel(round_fx(vx * bounce));
      if (py <= min_y) vy = clamp_vel(round_fx(vy * bounce));
      if (py >= max_y) begin
        vy = 0;
        vx = round_fx(vx * FRICTION);
      end
      if (px < min_x) px = min_x;
      else if (px > max_x) px = max_x;
      if (py < min_y) py = min_y;
      else if (py > max_y) py = max_y;
      r.new_pos_x = px[POS_W-1:0];
      r.new_pos_y = py[POS_W-1:0];
      r.new_vel_x = vx[VEL_W-1:0];
      r.new_vel_y = vy[VEL_W-1:0];
      r.last = p.last;
      return r;
    endfunction

    function void note_request(particle_t p);
      expected_steps = {expected_steps, euler_wall_step(p)};
    endfunction

    // output is capped so a badly broken design does not flood the log
    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 100)
        $display("ERROR %s: got 0x%0h want 0x%0h", what, got, want);
    endtask

    task check_result(step_result_t got);
      step_result_t want;
      if (expected_steps.size() == 0) begin
        report("result with no request pending", got.new_pos_x, 0);
        return;
      end
      want = expected_steps.pop_front();
      if (got.new_pos_x !== want.new_pos_x) report("new_pos_x", got.new_pos_x, want.new_pos_x);
      if (got.new_pos_y !== want.new_pos_y) report("new_pos_y", got.new_pos_y, want.new_pos_y);
      if (got.new_vel_x !== want.new_vel_x) report("new_vel_x", got.new_vel_x, want.new_vel_x);
      if (got.new_vel_y !== want.new_vel_y) report("new_vel_y", got.new_vel_y, want.new_vel_y);
      if (got.last !== want.last) report("last_out", got.last, want.last);
    endtask

    task flush_check();
      if (expected_steps.size() != 0)
        report("results never returned", expected_steps.size(), 0);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned hold_left = 0;
  step_scoreboard sb;

  pew_particle_if pin ();
  pew_result_if #(.FRAC_BITS(FB)) pout ();
  pew_cfg_if cfg_bus ();

  particle_euler_wall_step #(.FRAC_BITS(FB)) dut (
    .clk          (clk),
    .rst          (rst),
    .particle_in  (pin),
    .particle_out (pout),
    .cfg          (cfg_bus)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic particle_t mk_particle(longint px, longint py, longint vx, longint vy,
                                            bit last);
    particle_t p;
    p.pos_x = px[POS_W-1:0];
    p.pos_y = py[POS_W-1:0];
    p.vel_x = vx[POS_W-1:0];
    p.vel_y = vy[POS_W-1:0];
    p.last = last;
    return p;
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(0, 3))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // mostly inside or near the box, some anywhere
  function automatic longint rand_coord(longint lo, longint hi);
    longint a, b, span;
    int unsigned r;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a + 4 * ONE + 1;
    r = $urandom_range(0, 99);
    if (r < 50) return a - 2 * ONE + longint'({$urandom, $urandom} % span);
    if (r < 80)
      return ($urandom_range(0, 1) ? a : b) + longint'($urandom_range(0, 6 * ONE)) - 3 * ONE;
    if (r < 92) return longint'($urandom);
    return pick_extreme();
  endfunction

  function automatic longint rand_vel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return longint'($urandom_range(0, 60 * ONE)) - 30 * ONE;
    if (r < 75)
      return ($urandom_range(0, 1) ? VEL_LIM : -VEL_LIM) +
             longint'($urandom_range(0, 8)) - 4;
    if (r < 90) return longint'($urandom);
    return pick_extreme();
  endfunction

  function automatic particle_t rand_particle();
    return mk_particle(rand_coord(sb.min_x, sb.max_x), rand_coord(sb.min_y, sb.max_y),
                       rand_vel(), rand_vel(), $urandom_range(0, 7) == 0);
  endfunction

  function automatic longint rand_dt();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return longint'($urandom_range(0, 4 * 1092));
    if (r < 9) return longint'($urandom_range(0, ONE));
    return longint'($urandom_range(0, (1 << STEP_W) - 1));
  endfunction

  task automatic send_particle(particle_t p, int unsigned gap);
    pin.valid <= 1'b1;
    pin.pos_x <= p.pos_x;
    pin.pos_y <= p.pos_y;
    pin.vel_x <= p.vel_x;
    pin.vel_y <= p.vel_y;
    pin.last_in <= p.last;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    if (gap != 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drive_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit more);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (!more) cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_world(longint step, longint bnc, longint lo_x, longint lo_y,
                           longint hi_x, longint hi_y);
    drive_cfg(REG_TIME_STEP, step[31:0], 1'b1);
    drive_cfg(REG_BOUNCE_FACTOR, bnc[31:0], 1'b1);
    drive_cfg(REG_WORLD_MIN_X, lo_x[31:0], 1'b1);
    drive_cfg(REG_WORLD_MIN_Y, lo_y[31:0], 1'b1);
    drive_cfg(REG_WORLD_MAX_X, hi_x[31:0], 1'b1);
    drive_cfg(REG_WORLD_MAX_Y, hi_y[31:0], 1'b0);
  endtask

  // queue is sampled on the falling edge, after all rising-edge updates
  task automatic wait_idle();
    pin.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_steps.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_sink
    int unsigned g;
    if (rst) begin
      pout.ready <= 1'b0;
      hold_left <= 0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      pout.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pout.ready <= 1'b0;
    end else if (rx_steady) begin
      pout.ready <= 1'b1;
    end else begin
      g = idle_gap();
      if (g == 0) begin
        pout.ready <= 1'b1;
      end else begin
        pout.ready <= 1'b0;
        hold_left <= g - 1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    particle_t req;
    step_result_t got;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
      if (pin.valid && pin.ready) begin
        req.pos_x = pin.pos_x;
        req.pos_y = pin.pos_y;
        req.vel_x = pin.vel_x;
        req.vel_y = pin.vel_y;
        req.last = pin.last_in;
        sb.note_request(req);
      end
      if (pout.valid && pout.ready) begin
        got.new_pos_x = pout.new_pos_x;
        got.new_pos_y = pout.new_pos_y;
        got.new_vel_x = pout.new_vel_x;
        got.new_vel_y = pout.new_vel_y;
        got.last = pout.last_out;
        sb.check_result(got);
      end
    end
  end

  initial begin : stimulus
    longint lo_x, lo_y, hi_x, hi_y, w;
    int unsigned gap;
    int drain_cycles;
    sb = new();
    pin.valid = 1'b0;
    pin.pos_x = '0;
    pin.pos_y = '0;
    pin.vel_x = '0;
    pin.vel_y = '0;
    pin.last_in = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: walls, ceiling, floor, velocity clamps, field extremes
    send_particle(mk_particle(0, 0, 0, 0, 0), idle_gap());
    send_particle(mk_particle(500 * ONE, 500 * ONE, 3 * ONE, -2 * ONE, 1), idle_gap());
    send_particle(mk_particle(500 * ONE, 500 * ONE, 40 * ONE, -40 * ONE, 0), idle_gap());
    send_particle(mk_particle(500 * ONE, 500 * ONE, -40 * ONE, 40 * ONE, 1), idle_gap());
    send_particle(mk_particle(999 * ONE + 65000, 300 * ONE, 20 * ONE, 0, 0), idle_gap());
    send_particle(mk_particle(100, 300 * ONE, -20 * ONE, 0, 0), idle_gap());
    send_particle(mk_particle(300 * ONE, 100, 0, -20 * ONE, 0), idle_gap());
    send_particle(mk_particle(300 * ONE, 1000 * ONE - 100, 5 * ONE, 20 * ONE, 1), idle_gap());
    send_particle(mk_particle(300 * ONE, 1000 * ONE, 5 * ONE, -10920, 0), idle_gap());
    send_particle(mk_particle(1000 * ONE, 500 * ONE, 0, 0, 0), idle_gap());
    send_particle(mk_particle(1000 * ONE, 1000 * ONE, 25 * ONE, 25 * ONE, 1), idle_gap());
    send_particle(mk_particle(INT_MAX, INT_MAX, INT_MAX, INT_MAX, 1), idle_gap());
    send_particle(mk_particle(INT_MIN, INT_MIN, INT_MIN, INT_MIN, 0), idle_gap());
    send_particle(mk_particle(INT_MAX, INT_MIN, INT_MIN, INT_MAX, 1), idle_gap());
    send_particle(mk_particle(-1, -1, -1, -1, 1), idle_gap());
    wait_idle();

    // spare indexes are ignored; inverted x box, ceiling equal to floor,
    // bounce above one and an oversized step
    drive_cfg(REG_SPARE_A, $urandom, 1'b1);
    drive_cfg(REG_SPARE_B, 32'hffff_ffff, 1'b1);
    set_world(100000, 114688, 200 * ONE, 500 * ONE, 100 * ONE, 500 * ONE);
    send_particle(mk_particle(0, 0, 10 * ONE, 10 * ONE, 0), idle_gap());
    send_particle(mk_particle(600 * ONE, 500 * ONE, -20 * ONE, -20 * ONE, 1), idle_gap());
    send_particle(mk_particle(150 * ONE, 400 * ONE, 24 * ONE, -24 * ONE, 0), idle_gap());
    send_particle(mk_particle(150 * ONE, 600 * ONE, -3 * ONE, 30 * ONE, 1), idle_gap());
    send_particle(mk_particle(150 * ONE, 500 * ONE, 0, -1000000, 0), idle_gap());
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_world(ONE, ONE, -100 * ONE, -100 * ONE, 100 * ONE, 100 * ONE);
        1: set_world(0, -ONE, 0, 0, 10 * ONE, 10 * ONE);
        2: set_world(32'hffff_ffff, 32'h0001_ffff, INT_MIN, INT_MIN, INT_MAX, INT_MAX);
        3: set_world(rand_dt(), 32'hfffe_0000, 200 * ONE, 50 * ONE, 100 * ONE, 50 * ONE);
        4: set_world(1092, -(ONE / 2), 0, 0, 1000 * ONE, 1000 * ONE);
        default: begin
          w = longint'($urandom_range(0, 200)) * ONE;
          lo_x = longint'($urandom_range(0, 1000)) * ONE - 500 * ONE;
          lo_y = longint'($urandom_range(0, 1000)) * ONE - 500 * ONE;
          hi_x = ($urandom_range(0, 3) == 0) ? lo_x - w : lo_x + w;
          hi_y = lo_y + longint'($urandom_range(0, 200)) * ONE;
          drive_cfg(REG_SPARE_A, $urandom, 1'b1);
          set_world(rand_dt(), longint'($urandom), lo_x, lo_y, hi_x, hi_y);
        end
      endcase
      rx_steady <= (ph % 3 == 0);
      // output held off while the input keeps pushing, until the block backs up
      if (ph == 1) long_hold_req <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) wait_idle();
        if (ph % 3 == 0 || (ph == 1 && n < 40)) gap = 0;
        else gap = idle_gap();
        send_particle(rand_particle(), gap);
      end
      wait_idle();
    end

    pin.valid <= 1'b0;
    drain_cycles = 0;
    @(negedge clk);
    while (sb.expected_steps.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    sb.flush_check();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
design/pew_pkg.sv
design/pew_if.sv
design/pew_cfg_regs.sv
design/pew_kinematics.sv
design/pew_contact.sv
design/particle_euler_wall_step.sv
verif/particle_euler_wall_step_tb.sv
